### rtl/lgw_pkg.sv
// Shared types, codes and the seven-segment table for the two-wire LED grid writer.
package lgw_pkg;

  localparam logic [1:0] CMD_DIGIT = 2'd0;
  localparam logic [1:0] CMD_RAW   = 2'd1;
  localparam logic [1:0] CMD_INIT  = 2'd2;
  localparam logic [1:0] CMD_NONE  = 2'd3;

  localparam logic       CFG_DATA_CMD = 1'b0;
  localparam logic       CFG_DISP_CTL = 1'b1;

  localparam logic [7:0] DATA_CMD_RESET = 8'h44;
  localparam logic [7:0] DISP_CTL_RESET = 8'h8F;
  localparam logic [7:0] GRID_CMD_BASE  = 8'hC0;

  localparam logic [1:0] PART_START = 2'd0;
  localparam logic [1:0] PART_BYTE  = 2'd1;
  localparam logic [1:0] PART_STOP  = 2'd2;

  localparam logic [3:0] BIT_TRAIL  = 4'd8;

  // One queued run: a two-byte frame, or two one-byte frames for init
  typedef struct packed {
    logic       init;
    logic [7:0] b0;
    logic [7:0] b1;
  } desc_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic logic [7:0] seg_lookup(input logic [7:0] idx);
    logic [7:0] s;
    case (idx)
      8'd0:    s = 8'h3F;
      8'd1:    s = 8'h06;
      8'd2:    s = 8'h5B;
      8'd3:    s = 8'h4F;
      8'd4:    s = 8'h66;
      8'd5:    s = 8'h6D;
      8'd6:    s = 8'h7D;
      8'd7:    s = 8'h07;
      8'd8:    s = 8'h7F;
      8'd9:    s = 8'h6F;
      8'd10:   s = 8'hBF;
      8'd11:   s = 8'h86;
      8'd12:   s = 8'hDB;
      8'd13:   s = 8'hCF;
      8'd14:   s = 8'hE6;
      8'd15:   s = 8'hED;
      8'd16:   s = 8'hFD;
      8'd17:   s = 8'h87;
      8'd18:   s = 8'hFF;
      8'd19:   s = 8'hEF;
      default: s = 8'h00;
    endcase
    return s;
  endfunction

endpackage

### rtl/led_grid_two_wire_writer_unit.sv
// Two-wire LED grid writer: command in, one pin state beat per cycle out unless stalled.
// An accepted command passes the queue, sequencer state and output register to the pins.
// Throughput: one beat per cycle unless pin_stall holds it; a digit or raw command gives
//   55 beats, init 60; the next run is popped on the final stop beat of the current run.
// Reset: queue emptied, sequencer idle, no beat shown; config bytes back to 0x44 and 0x8F.
module led_grid_two_wire_writer_unit
  import lgw_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  // config write port
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data,
  // command channel
  input  logic       cmd_valid,
  output logic       cmd_stall,
  input  logic [1:0] command,
  input  logic [3:0] grid_address,
  input  logic [7:0] value,
  // pin state channel
  output logic       pin_valid,
  input  logic       pin_stall,
  output logic       clock_pin,
  output logic       data_pin,
  output logic       last
);

  logic      push;
  desc_t     push_desc;
  logic      pop;
  desc_t     head;
  q_status_t q_status;

  // Front only stalls when the queue is full; a meaningless command code
  // is taken and dropped without touching the queue.
  assign cmd_stall = q_status.full;

  lgw_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .cmd_valid    (cmd_valid),
    .command      (command),
    .grid_address (grid_address),
    .value        (value),
    .q_status     (q_status),
    .push         (push),
    .push_desc    (push_desc)
  );

  // Two runs of slack lets the front take the next command while the
  // back is still clocking out the current frame.
  lgw_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_desc (push_desc),
    .pop       (pop),
    .head      (head),
    .q_status  (q_status)
  );

  // Sequencer walks start, bytes (LSB first, three states a bit plus a
  // trailing low) and stop; the output register holds a shown beat while pin_stall is high.
  lgw_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .q_status  (q_status),
    .pop       (pop),
    .pin_stall (pin_stall),
    .pin_valid (pin_valid),
    .clock_pin (clock_pin),
    .data_pin  (data_pin),
    .last      (last)
  );

  a_queue_flags : assert property (@(posedge clk) disable iff (rst)
    !(q_status.full && q_status.empty))
    else $error("queue reports full and empty together");

  a_push_only_valid_cmd : assert property (@(posedge clk) disable iff (rst)
    push |-> (cmd_valid && !cmd_stall && (command != CMD_NONE)))
    else $error("queue written without a valid accepted command");

  a_no_pop_empty : assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_status.empty)
    else $error("queue popped while empty");

  a_last_is_stop : assert property (@(posedge clk) disable iff (rst)
    (pin_valid && last) |-> (clock_pin && data_pin))
    else $error("last beat is not the end of a stop condition");

endmodule

### rtl/lgw_front.sv
// Front end: config registers, command accept and frame byte set-up.
module lgw_front
  import lgw_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data,
  input  logic       cmd_valid,
  input  logic [1:0] command,
  input  logic [3:0] grid_address,
  input  logic [7:0] value,
  input  q_status_t  q_status,
  output logic       push,
  output desc_t      push_desc
);

  logic [7:0] data_cmd;
  logic [7:0] disp_ctl;
  logic       accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      data_cmd <= DATA_CMD_RESET;
      disp_ctl <= DISP_CTL_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DATA_CMD: data_cmd <= cfg_data;
        CFG_DISP_CTL: disp_ctl <= cfg_data;
        default: ;
      endcase
    end
  end

  assign accept = cmd_valid && !q_status.full;

  always_comb begin
    push_desc.init = 1'b0;
    push_desc.b0   = GRID_CMD_BASE + {4'd0, grid_address};
    push_desc.b1   = value;
    push           = 1'b0;
    case (command)
      CMD_DIGIT: begin
        push_desc.b1 = seg_lookup(value);
        push         = accept;
      end
      CMD_RAW: begin
        push = accept;
      end
      CMD_INIT: begin
        push_desc.init = 1'b1;
        push_desc.b0   = data_cmd;
        push_desc.b1   = disp_ctl;
        push           = accept;
      end
      default: ; // meaningless code: taken and dropped
    endcase
  end

endmodule

### rtl/lgw_queue.sv
// Two-entry run queue between front end and pin sequencer.
module lgw_queue
  import lgw_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  desc_t     push_desc,
  input  logic      pop,
  output desc_t     head,
  output q_status_t q_status
);

  desc_t      mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  assign head           = mem[rd_ptr];
  assign q_status.full  = (count == 2'd2);
  assign q_status.empty = (count == 2'd0);

endmodule

### rtl/lgw_back.sv
// Back end: pin state sequencer and output register.
module lgw_back
  import lgw_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  desc_t     head,
  input  q_status_t q_status,
  output logic      pop,
  input  logic      pin_stall,
  output logic      pin_valid,
  output logic      clock_pin,
  output logic      data_pin,
  output logic      last
);

  logic       busy, busy_next;
  logic [1:0] part, part_next;
  logic [1:0] sub, sub_next;
  logic [3:0] bitn, bitn_next;
  logic       byte_sel, byte_sel_next;
  logic       frame_sel, frame_sel_next;
  logic [7:0] sh, sh_next;
  logic       prev, prev_next;
  desc_t      d, d_next;

  logic       adv;
  logic       clk_s, dat_s, last_s;
  logic       run_done;

  assign adv = !pin_valid || !pin_stall;

  always_comb begin
    part_next      = part;
    sub_next       = sub;
    bitn_next      = bitn;
    byte_sel_next  = byte_sel;
    frame_sel_next = frame_sel;
    sh_next        = sh;
    prev_next      = prev;
    clk_s          = 1'b0;
    dat_s          = 1'b0;
    last_s         = 1'b0;
    run_done       = 1'b0;
    case (part)
      PART_START: begin
        clk_s = (sub != 2'd2);
        dat_s = (sub == 2'd0);
        if (sub == 2'd2) begin
          part_next     = PART_BYTE;
          sub_next      = 2'd0;
          bitn_next     = 4'd0;
          prev_next     = 1'b0;
          byte_sel_next = 1'b0;
          sh_next       = frame_sel ? d.b1 : d.b0;
        end else begin
          sub_next = sub + 2'd1;
        end
      end
      PART_BYTE: begin
        if (bitn == BIT_TRAIL) begin
          if (!d.init && !byte_sel) begin
            byte_sel_next = 1'b1;
            sh_next       = d.b1;
            bitn_next     = 4'd0;
            prev_next     = 1'b0;
          end else begin
            part_next = PART_STOP;
            sub_next  = 2'd0;
          end
        end else begin
          clk_s = (sub == 2'd2);
          dat_s = (sub == 2'd0) ? prev : sh[0];
          if (sub == 2'd2) begin
            prev_next = sh[0];
            sh_next   = {1'b0, sh[7:1]};
            bitn_next = bitn + 4'd1;
            sub_next  = 2'd0;
          end else begin
            sub_next = sub + 2'd1;
          end
        end
      end
      PART_STOP: begin
        clk_s = 1'b1;
        dat_s = (sub == 2'd1);
        if (sub == 2'd1) begin
          if (!d.init || frame_sel) begin
            last_s   = 1'b1;
            run_done = 1'b1;
          end else begin
            frame_sel_next = 1'b1;
            part_next      = PART_START;
            sub_next       = 2'd0;
          end
        end else begin
          sub_next = 2'd1;
        end
      end
      default: begin
        part_next = PART_START;
        sub_next  = 2'd0;
      end
    endcase

    pop       = 1'b0;
    busy_next = busy;
    d_next    = d;
    if (!busy || (adv && run_done)) begin
      busy_next = !q_status.empty;
      if (!q_status.empty) begin
        pop            = 1'b1;
        d_next         = head;
        part_next      = PART_START;
        sub_next       = 2'd0;
        frame_sel_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      part      <= PART_START;
      sub       <= 2'd0;
      pin_valid <= 1'b0;
    end else begin
      if (!busy || adv) begin
        busy <= busy_next;
        part <= part_next;
        sub  <= sub_next;
      end
      if (adv) pin_valid <= busy;
    end
  end

  always_ff @(posedge clk) begin
    if (!busy || adv) begin
      bitn      <= bitn_next;
      byte_sel  <= byte_sel_next;
      frame_sel <= frame_sel_next;
      sh        <= sh_next;
      prev      <= prev_next;
      d         <= d_next;
    end
    if (adv) begin
      clock_pin <= clk_s;
      data_pin  <= dat_s;
      last      <= last_s;
    end
  end

endmodule

### verif/tb_top.sv
// Self-checking testbench for the two-wire LED grid writer: display commands in, pin beats out.
`timescale 1ns / 100ps

module tb_top;
  import lgw_pkg::*;

  // Quiet cycles (no beat accepted on either side) before the run is declared hung.
  // The longest legitimate quiet stretch comes from the output hold-off below.
  localparam int QUIET_LIMIT  = 2000;
  localparam int HOLD_CYCLES  = 300;
  // After the last expected pin beat, pause before touching the registers, so that a beat
  // wrongly made from an ignored command would still be seen by the checker.
  localparam int SETTLE_CYCLES = 8;

  // Seven-segment patterns, entry 0 in the low byte; index 20 is blank.
  localparam logic [21*8-1:0] SEGMENT_PATTERNS = {
    8'h00, 8'hEF, 8'hFF, 8'h87, 8'hFD, 8'hED, 8'hE6, 8'hCF, 8'hDB, 8'h86, 8'hBF,
    8'h6F, 8'h7F, 8'h07, 8'h7D, 8'h6D, 8'h66, 8'h4F, 8'h5B, 8'h06, 8'h3F
  };

  typedef struct packed {
    logic clk_lvl;
    logic dat_lvl;
    logic end_mark;
  } pin_state_t;

  logic       clk          = 1'b0;
  logic       rst          = 1'b1;
  logic       cfg_we       = 1'b0;
  logic       cfg_index    = CFG_DATA_CMD;
  logic [7:0] cfg_data     = 8'h00;
  logic       cmd_valid    = 1'b0;
  logic       cmd_stall;
  logic [1:0] command      = CMD_DIGIT;
  logic [3:0] grid_address = 4'h0;
  logic [7:0] value        = 8'h00;
  logic       pin_valid;
  logic       pin_stall    = 1'b0;
  logic       clock_pin;
  logic       data_pin;
  logic       last;

  led_grid_two_wire_writer_unit uut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .cmd_valid    (cmd_valid),
    .cmd_stall    (cmd_stall),
    .command      (command),
    .grid_address (grid_address),
    .value        (value),
    .pin_valid    (pin_valid),
    .pin_stall    (pin_stall),
    .clock_pin    (clock_pin),
    .data_pin     (data_pin),
    .last         (last)
  );

  initial forever #5 clk = ~clk;

  // Predictor state: its own copy of the two init bytes and the expected pin waveform
  pin_state_t expected_pins[$];
  logic [7:0] data_cmd_copy = DATA_CMD_RESET;
  logic [7:0] disp_ctl_copy = DISP_CTL_RESET;
  logic       line_level;

  int fail_count     = 0;
  int commands_sent  = 0;
  int beats_checked  = 0;
  int tx_idle_pct    = 0;
  int rx_stall_pct   = 0;
  int hold_left      = 0;
  int quiet_cycles   = 0;

  // ---------------------------------------------------------------------------
  // Waveform predictor
  // ---------------------------------------------------------------------------
  function automatic void put_pins(logic c, logic d);
    pin_state_t s;
    s.clk_lvl  = c;
    s.dat_lvl  = d;
    s.end_mark = 1'b0;
    expected_pins.push_back(s);
    line_level = d;
  endfunction

  function automatic void put_start_cond();
    put_pins(1'b1, 1'b1);
    put_pins(1'b1, 1'b0);
    put_pins(1'b0, 1'b0);
  endfunction

  function automatic void put_stop_cond();
    put_pins(1'b1, 1'b0);
    put_pins(1'b1, 1'b1);
  endfunction

  // LSB first; each bit holds the previous level, sets the new one, then clocks it
  function automatic void put_serial_byte(logic [7:0] b);
    for (int i = 0; i < 8; i++) begin
      put_pins(1'b0, line_level);
      put_pins(1'b0, b[i]);
      put_pins(1'b1, b[i]);
    end
    put_pins(1'b0, 1'b0);
  endfunction

  function automatic void predict_waveform(logic [1:0] cmd, logic [3:0] addr, logic [7:0] val);
    logic [7:0] grid_byte;
    logic [7:0] seg_byte;
    pin_state_t tail;
    if (cmd == CMD_NONE) return;
    line_level = 1'b0;
    if (cmd == CMD_INIT) begin
      put_start_cond();
      put_serial_byte(data_cmd_copy);
      put_stop_cond();
      put_start_cond();
      put_serial_byte(disp_ctl_copy);
      put_stop_cond();
    end else begin
      grid_byte = GRID_CMD_BASE + {4'h0, addr};
      if (cmd == CMD_DIGIT)
        seg_byte = (val <= 8'd20) ? SEGMENT_PATTERNS[val*8 +: 8] : 8'h00;
      else
        seg_byte = val;
      put_start_cond();
      put_serial_byte(grid_byte);
      put_serial_byte(seg_byte);
      put_stop_cond();
    end
    tail = expected_pins.pop_back();
    tail.end_mark = 1'b1;
    expected_pins.push_back(tail);
  endfunction

  // ---------------------------------------------------------------------------
  // Receiver side: random stall, or a long hold-off counted down here
  // ---------------------------------------------------------------------------
  initial begin : pin_receiver
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        pin_stall <= 1'b1;
        hold_left--;
      end else begin
        pin_stall <= ($urandom_range(99) < rx_stall_pct);
      end
    end
  end

  // Pin beat checker: every accepted beat against the oldest expectation
  always @(posedge clk) begin : pin_checker
    pin_state_t want;
    if (!rst && pin_valid && !pin_stall) begin
      if (expected_pins.size() == 0) begin
        $error("pin beat with nothing expected: clock_pin=%0b data_pin=%0b last=%0b",
               clock_pin, data_pin, last);
        fail_count++;
      end else begin
        want = expected_pins.pop_front();
        beats_checked++;
        if (clock_pin !== want.clk_lvl) begin
          $error("clock_pin: expected %0b, got %0b", want.clk_lvl, clock_pin);
          fail_count++;
        end
        if (data_pin !== want.dat_lvl) begin
          $error("data_pin: expected %0b, got %0b", want.dat_lvl, data_pin);
          fail_count++;
        end
        if (last !== want.end_mark) begin
          $error("last: expected %0b, got %0b", want.end_mark, last);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: a long run of cycles with no beat on either channel means a hang
  always @(posedge clk) begin
    if (rst || (cmd_valid && !cmd_stall) || (pin_valid && !pin_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Watchdog: no beat for %0d cycles, %0d pin beats outstanding",
               QUIET_LIMIT, expected_pins.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Shared driving tasks
  // ---------------------------------------------------------------------------
  // Offers one command beat after an optional random gap. Valid is left high on
  // return so back-to-back beats need no gap; a drain, or a gap in the next call, lowers it.
  task automatic send_command(logic [1:0] cmd, logic [3:0] addr, logic [7:0] val);
    while ($urandom_range(99) < tx_idle_pct) begin
      cmd_valid <= 1'b0;
      @(posedge clk);
    end
    cmd_valid    <= 1'b1;
    command      <= cmd;
    grid_address <= addr;
    value        <= val;
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
    predict_waveform(cmd, addr, val);
    commands_sent++;
  endtask

  // Stops offering, waits for every expected beat, then lets the pipeline settle
  task automatic drain_to_idle();
    cmd_valid <= 1'b0;
    while (expected_pins.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes both init bytes; only ever called with the block idle
  task automatic write_init_bytes(logic [7:0] data_cmd, logic [7:0] disp_ctl);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_DATA_CMD;
    cfg_data  <= data_cmd;
    @(posedge clk);
    data_cmd_copy = data_cmd;
    cfg_index <= CFG_DISP_CTL;
    cfg_data  <= disp_ctl;
    @(posedge clk);
    disp_ctl_copy = disp_ctl;
    cfg_we    <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Init straight after reset shows the reset values of both init bytes
  task automatic test_reset_defaults();
    send_command(CMD_INIT, 4'h0, 8'h00);
    drain_to_idle();
  endtask

  // Segment table edges, blank and out-of-range digits, raw extremes, both grid
  // address extremes, and the unused command code which must give nothing
  task automatic test_directed_commands();
    send_command(CMD_DIGIT, 4'h0, 8'd0);
    send_command(CMD_DIGIT, 4'hF, 8'd9);
    send_command(CMD_DIGIT, 4'h5, 8'd10);
    send_command(CMD_DIGIT, 4'hA, 8'd19);
    send_command(CMD_DIGIT, 4'h3, 8'd20);
    send_command(CMD_DIGIT, 4'hC, 8'd21);
    send_command(CMD_DIGIT, 4'hF, 8'd255);
    send_command(CMD_NONE, 4'hF, 8'hFF);
    send_command(CMD_RAW, 4'h0, 8'h00);
    send_command(CMD_RAW, 4'hF, 8'hFF);
    send_command(CMD_NONE, 4'h0, 8'h00);
    send_command(CMD_RAW, 4'h9, 8'hA5);
    send_command(CMD_RAW, 4'h6, 8'h5A);
    drain_to_idle();
  endtask

  // Init bytes at all-zeros and all-ones, both ways round
  task automatic test_register_extremes();
    write_init_bytes(8'h00, 8'hFF);
    send_command(CMD_INIT, 4'h7, 8'h11);
    drain_to_idle();
    write_init_bytes(8'hFF, 8'h00);
    send_command(CMD_INIT, 4'h8, 8'hEE);
    drain_to_idle();
  endtask

  // Random mix under one idling regime; ignored commands do not count
  task automatic test_random_mix(int n_items, int tx_pct, int rx_pct);
    int done;
    int pick;
    logic [1:0] cmd;
    logic [7:0] val;
    done = 0;
    tx_idle_pct  = tx_pct;
    rx_stall_pct = rx_pct;
    write_init_bytes(8'($urandom_range(255)), 8'($urandom_range(255)));
    while (done < n_items) begin
      pick = $urandom_range(99);
      if (pick < 40) cmd = CMD_DIGIT;
      else if (pick < 75) cmd = CMD_RAW;
      else if (pick < 95) cmd = CMD_INIT;
      else cmd = CMD_NONE;
      // digits mostly in table range, the rest anywhere
      if (cmd == CMD_DIGIT && $urandom_range(99) < 85)
        val = 8'($urandom_range(20));
      else
        val = 8'($urandom_range(255));
      send_command(cmd, 4'($urandom_range(15)), val);
      if (cmd != CMD_NONE) done++;
    end
    drain_to_idle();
  endtask

  // Receiver holds off for a long stretch while commands keep coming, so the
  // block fills and has to stall its command input
  task automatic test_output_hold_off();
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    hold_left    = HOLD_CYCLES;
    for (int i = 0; i < 8; i++)
      send_command(i[0] ? CMD_RAW : CMD_DIGIT, 4'($urandom_range(15)),
                   8'($urandom_range(255)));
    drain_to_idle();
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_defaults();
    test_directed_commands();
    test_register_extremes();
    test_random_mix(48, 25, 51);
    test_random_mix(48, 51, 25);
    test_random_mix(40, 0, 0);
    test_output_hold_off();

    if (expected_pins.size() != 0) begin
      $error("%0d pin beats never arrived", expected_pins.size());
      fail_count++;
    end

    $display("Covered: %0d commands (digit, raw, init, unused code) and %0d pin beats checked,",
             commands_sent, beats_checked);
    $display("  register extremes, three idling regimes and a long output hold-off.");
    if (fail_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

### filelist.f
rtl/lgw_pkg.sv
rtl/lgw_front.sv
rtl/lgw_queue.sv
rtl/lgw_back.sv
rtl/led_grid_two_wire_writer_unit.sv
verif/tb_top.sv
